@@ design/assert_macros.svh @@
// Assertion macros shared by the speed loop RTL.
// Included by every file that carries concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

@@ design/fipid_pkg.sv @@
// Types and constants of the filtered incremental PID speed loop.
// Used by the channel interfaces, the controller, the datapath and the top level.
package fipid_pkg;

  localparam int DATA_W    = 32;  // Q16.16 samples, setpoints, gains
  localparam int ALPHA_W   = 16;  // filter pole, Q0.16
  localparam int DUTY_W    = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: gains times error terms, or unsigned words times history or duty values
  localparam int MUL_A_W = DATA_W + 1;
  localparam int MUL_B_W = DATA_W + 2;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  // floor(x / 100) for 32-bit x as (x * DIV100_MUL) >> DIV100_SHIFT
  localparam int                 DIV_IN_W     = 32;
  localparam int                 DIV100_SHIFT = 38;
  localparam logic [MUL_A_W-1:0] DIV100_MUL   = 33'd2748779070;

  localparam logic [ALPHA_W:0] ALPHA_ONE = 17'h10000;

  localparam logic signed [DATA_W-1:0] KP_RESET     = 32'sd65536;
  localparam logic [ALPHA_W-1:0]       ALPHA_RESET  = 16'd24109;
  localparam logic [DUTY_W-1:0]        PERIOD_RESET = 16'd1000;
  localparam logic [DUTY_W-1:0]        LIMIT_RESET  = 16'd90;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CONTROL = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_PERIOD = 3'd4,
    REG_LIMIT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_FIN   = 3'd0,  // (1 - alpha) * raw history
    MUL_FOUT  = 3'd1,  // alpha * filter history
    MUL_KP    = 3'd2,
    MUL_KI    = 3'd3,
    MUL_KD    = 3'd4,
    MUL_DUTY  = 3'd5,  // |u| * period
    MUL_RECIP = 3'd6   // scaled duty times reciprocal of 100
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD      = 3'd0,
    ACC_LOAD_RAW  = 3'd1,
    ACC_ADD_RAW   = 3'd2,
    ACC_LOAD_CTRL = 3'd3,  // previous control value plus scaled product
    ACC_ADD_FRAC  = 3'd4
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     err_calc;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     filt_upd;
    logic     pid_upd;
    logic     duty_upd;
    logic     restart;
    logic     out_load;
  } dp_cmd_t;

endpackage

@@ design/fipid_in_if.sv @@
// Input channel of the speed loop: command code and Q16.16 value.
// Depends on fipid_pkg.
interface fipid_in_if import fipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

@@ design/fipid_out_if.sv @@
// Result channel of the speed loop: estimate, control value, duty, direction.
// Depends on fipid_pkg.
interface fipid_out_if import fipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] speed_estimate;
  logic signed [DATA_W-1:0] control_value;
  logic [DUTY_W-1:0]        duty;
  logic                     direction;

  modport source (output valid, speed_estimate, control_value, duty, direction, input ready);
  modport sink   (input valid, speed_estimate, control_value, duty, direction, output ready);
endinterface

@@ design/fipid_cfg_if.sv @@
// Register write channel of the speed loop: register index and write data.
// Depends on fipid_pkg.
interface fipid_cfg_if import fipid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/fipid_ctrl.sv @@
// Sequencer of the speed loop: one-hot state machine issuing datapath commands
// and owning the input ready and result valid. Depends on fipid_pkg.
`include "assert_macros.svh"

module fipid_ctrl import fipid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output dp_cmd_t          dp_cmd
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_F0   = 16'h0002,
    ST_F1   = 16'h0004,
    ST_F2   = 16'h0008,
    ST_F3   = 16'h0010,
    ST_E    = 16'h0020,
    ST_P    = 16'h0040,
    ST_I    = 16'h0080,
    ST_D    = 16'h0100,
    ST_U    = 16'h0200,
    ST_SAT  = 16'h0400,
    ST_DP   = 16'h0800,
    ST_DR   = 16'h1000,
    ST_DQ   = 16'h2000,
    ST_CLR  = 16'h4000,
    ST_OUT  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    dp_cmd          = '0;
    dp_cmd.mul_sel  = MUL_FIN;
    dp_cmd.acc_op   = ACC_HOLD;
    case (state_r)
      ST_IDLE: begin
        dp_cmd.capture = in_fire;
        if (in_fire) begin
          case (in_command)
            CMD_SAMPLE:  state_nxt = ST_F0;
            CMD_CONTROL: state_nxt = ST_E;
            CMD_RESTART: state_nxt = ST_CLR;
            default:     state_nxt = ST_OUT;  // unused code reports state only
          endcase
        end
      end
      ST_F0: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_FIN;
        state_nxt      = ST_F1;
      end
      ST_F1: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_FOUT;
        dp_cmd.acc_op  = ACC_LOAD_RAW;
        state_nxt      = ST_F2;
      end
      ST_F2: begin
        dp_cmd.acc_op = ACC_ADD_RAW;
        state_nxt     = ST_F3;
      end
      ST_F3: begin
        dp_cmd.filt_upd = 1'b1;
        state_nxt       = ST_OUT;
      end
      ST_E: begin
        dp_cmd.err_calc = 1'b1;
        state_nxt       = ST_P;
      end
      ST_P: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_KP;
        state_nxt      = ST_I;
      end
      ST_I: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_KI;
        dp_cmd.acc_op  = ACC_LOAD_CTRL;
        state_nxt      = ST_D;
      end
      ST_D: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_KD;
        dp_cmd.acc_op  = ACC_ADD_FRAC;
        state_nxt      = ST_U;
      end
      ST_U: begin
        dp_cmd.acc_op = ACC_ADD_FRAC;
        state_nxt     = ST_SAT;
      end
      ST_SAT: begin
        dp_cmd.pid_upd = 1'b1;
        state_nxt      = ST_DP;
      end
      ST_DP: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_DUTY;
        state_nxt      = ST_DR;
      end
      ST_DR: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_RECIP;
        state_nxt      = ST_DQ;
      end
      ST_DQ: begin
        dp_cmd.duty_upd = 1'b1;
        state_nxt       = ST_OUT;
      end
      ST_CLR: begin
        dp_cmd.restart = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        // wait for the result register to be free
        if (!out_valid_r || out_ready) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_fire, state_r != ST_IDLE)
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst_n, dp_cmd.out_load, !out_valid_r || out_ready)
  `ASSERT_NEXT(a_load_shows_result, clk, rst_n, dp_cmd.out_load, out_valid_r)

endmodule

@@ design/fipid_dp.sv @@
// Datapath of the speed loop: registers, loop state, one shared multiplier,
// accumulator, saturation and duty scaling. Depends on fipid_pkg and fipid_cfg_if.
module fipid_dp import fipid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  fipid_cfg_if.sink                cfg_if,
  input  logic signed [DATA_W-1:0] in_value,
  input  dp_cmd_t                  dp_cmd,
  output logic signed [DATA_W-1:0] speed_estimate,
  output logic signed [DATA_W-1:0] control_value,
  output logic [DUTY_W-1:0]        duty,
  output logic                     direction
);

  localparam int QUO_W = PROD_W - DIV100_SHIFT;

  localparam logic signed [ACC_W-1:0] DMAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DMIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > DMAX) begin
      r = DMAX[DATA_W-1:0];
    end else if (x < DMIN) begin
      r = DMIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [MUL_B_W-1:0] sx_b(input logic signed [DATA_W-1:0] x);
    return {{(MUL_B_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx_acc(input logic signed [DATA_W-1:0] x);
    return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  // configuration
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r;
  logic [ALPHA_W-1:0]       alpha_r;
  logic [DUTY_W-1:0]        period_r, limit_r;

  // loop state
  logic signed [DATA_W-1:0] fout_r, fin_r, est_r, e1_r, e2_r, ctl_r;
  logic [DUTY_W-1:0]        duty_r;
  logic                     dir_r;

  // working registers
  logic signed [DATA_W-1:0] value_r, e_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic [ALPHA_W:0]         w_in;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] e_x, diff_p, sum_i, diff_d, ctl_x, abs_u;
  logic [DIV_IN_W-1:0]      scaled_duty;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  raw_term, frac_term;
  logic signed [DATA_W-1:0] filt_est, e_calc, u_sat;
  logic [QUO_W-1:0]         quo;
  logic [DUTY_W-1:0]        duty_calc;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= KP_RESET;
      ki_r     <= '0;
      kd_r     <= '0;
      alpha_r  <= ALPHA_RESET;
      period_r <= PERIOD_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_KP:     kp_r     <= cfg_if.data;
        REG_KI:     ki_r     <= cfg_if.data;
        REG_KD:     kd_r     <= cfg_if.data;
        REG_ALPHA:  alpha_r  <= cfg_if.data[ALPHA_W-1:0];
        REG_PERIOD: period_r <= cfg_if.data[DUTY_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_if.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // operand preparation
  assign w_in   = ALPHA_ONE - {1'b0, alpha_r};
  assign e_x    = sx_b(e_r);
  assign diff_p = e_x - sx_b(e1_r);
  assign sum_i  = e_x + sx_b(e1_r);
  assign diff_d = e_x - (sx_b(e1_r) <<< 1) + sx_b(e2_r);
  assign ctl_x  = sx_b(ctl_r);
  assign abs_u  = ctl_x[MUL_B_W-1] ? -ctl_x : ctl_x;

  // |u|*period is never negative; anything past 32 bits caps the duty anyway
  assign scaled_duty = (|prod_r[PROD_W-1:FRAC_BITS+DIV_IN_W]) ? '1 :
                       prod_r[FRAC_BITS+DIV_IN_W-1:FRAC_BITS];

  always_comb begin
    case (dp_cmd.mul_sel)
      MUL_FIN: begin
        mul_a = {{(MUL_A_W-ALPHA_W-1){1'b0}}, w_in};
        mul_b = sx_b(fin_r);
      end
      MUL_FOUT: begin
        mul_a = {{(MUL_A_W-ALPHA_W){1'b0}}, alpha_r};
        mul_b = sx_b(fout_r);
      end
      MUL_KP: begin
        mul_a = {kp_r[DATA_W-1], kp_r};
        mul_b = diff_p;
      end
      MUL_KI: begin
        mul_a = {ki_r[DATA_W-1], ki_r};
        mul_b = sum_i;
      end
      MUL_KD: begin
        mul_a = {kd_r[DATA_W-1], kd_r};
        mul_b = diff_d;
      end
      MUL_DUTY: begin
        mul_a = {{(MUL_A_W-DUTY_W){1'b0}}, period_r};
        mul_b = abs_u;
      end
      MUL_RECIP: begin
        mul_a = DIV100_MUL;
        mul_b = {{(MUL_B_W-DIV_IN_W){1'b0}}, scaled_duty};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // accumulator terms
  assign prod_sh   = prod_r >>> FRAC_BITS;
  assign raw_term  = {prod_r[PROD_W-1], prod_r};
  assign frac_term = {prod_sh[PROD_W-1], prod_sh};

  always_comb begin
    case (dp_cmd.acc_op)
      ACC_HOLD:      acc_nxt = acc_r;
      ACC_LOAD_RAW:  acc_nxt = raw_term;
      ACC_ADD_RAW:   acc_nxt = acc_r + raw_term;
      ACC_LOAD_CTRL: acc_nxt = sx_acc(ctl_r) + frac_term;
      ACC_ADD_FRAC:  acc_nxt = acc_r + frac_term;
      default:       acc_nxt = acc_r;
    endcase
  end

  assign filt_est = sat_acc(acc_r >>> ALPHA_W);
  assign e_calc   = sat_acc(sx_acc(value_r) - sx_acc(est_r));
  assign u_sat    = sat_acc(acc_r);

  assign quo       = prod_r[PROD_W-1:DIV100_SHIFT];
  assign duty_calc = (quo > QUO_W'(limit_r)) ? limit_r : quo[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      value_r <= in_value;
    end
    if (dp_cmd.err_calc) begin
      e_r <= e_calc;
    end
    if (dp_cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (dp_cmd.out_load) begin
      speed_estimate <= est_r;
      control_value  <= ctl_r;
      duty           <= duty_r;
      direction      <= dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fout_r <= '0;
      fin_r  <= '0;
      est_r  <= '0;
      e1_r   <= '0;
      e2_r   <= '0;
      ctl_r  <= '0;
      duty_r <= '0;
      dir_r  <= 1'b0;
    end else begin
      if (dp_cmd.filt_upd) begin
        est_r  <= filt_est;
        fout_r <= filt_est;
        fin_r  <= value_r;
      end
      if (dp_cmd.pid_upd) begin
        ctl_r <= u_sat;
        e2_r  <= e1_r;
        e1_r  <= e_r;
        dir_r <= value_r[DATA_W-1];
      end
      if (dp_cmd.duty_upd) begin
        duty_r <= duty_calc;
      end
      if (dp_cmd.restart) begin
        e1_r  <= '0;
        e2_r  <= '0;
        ctl_r <= '0;
        est_r <= '0;
      end
    end
  end

endmodule

@@ design/filtered_incremental_pid_speed_top.sv @@
// Top level of the filtered incremental PID speed loop.
// Joins fipid_ctrl and fipid_dp; depends on fipid_pkg and the three channel interfaces.
//
// Usage:
//   in_if  : one beat per command. SAMPLE feeds a measured speed into the low-pass
//            filter, CONTROL runs one PID step against the setpoint in value,
//            RESTART clears errors, control value and estimate (filter memory kept).
//   out_if : exactly one beat per input beat, showing estimate, control value,
//            duty and direction after that command.
//   cfg_if : register writes, always ready; write only while the loop is idle.
// Timing: one item at a time through a single shared multiplier; a new beat is
//   taken only once the previous item has loaded its result into the output
//   register. SAMPLE runs two filter multiplies and the estimate update; CONTROL
//   runs the error, five multiplies (three gains, duty scale, divide by 100) and
//   saturation; RESTART clears loop state; an unused code only reports state.
// Reset: synchronous, active low; registers return to their defaults and all
//   loop state clears. A stalled result holds in the output register; the next
//   beat is taken and computed meanwhile, and waits until that register frees.
module filtered_incremental_pid_speed_top import fipid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fipid_in_if.sink    in_if,
  fipid_out_if.source out_if,
  fipid_cfg_if.sink   cfg_if
);

  dp_cmd_t dp_cmd;

  fipid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .dp_cmd     (dp_cmd)
  );

  fipid_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_if         (cfg_if),
    .in_value       (in_if.value),
    .dp_cmd         (dp_cmd),
    .speed_estimate (out_if.speed_estimate),
    .control_value  (out_if.control_value),
    .duty           (out_if.duty),
    .direction      (out_if.direction)
  );

endmodule

@@ verif/filtered_incremental_pid_speed_top_tb.sv @@
// Testbench for filtered_incremental_pid_speed_top: drives sample, control, restart
// and unused commands under random idling and checks every result beat against a
// scoreboard that predicts the filter and the PID loop. Depends on fipid_pkg and interfaces.
module filtered_incremental_pid_speed_top_tb import fipid_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS_TB  = 16;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 241;

  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] est;
    logic signed [DATA_W-1:0] ctrl;
    logic [DUTY_W-1:0]        duty;
    logic                     dir;
  } loop_report_t;

  class pid_loop_scoreboard;
    logic signed [DATA_W-1:0] kp, ki, kd;
    logic [ALPHA_W-1:0]       alpha;
    logic [DUTY_W-1:0]        period, limit;

    logic signed [DATA_W-1:0] filt_out_mem, filt_in_mem, est_now;
    logic signed [DATA_W-1:0] err_prev, err_prev2, ctrl_now;
    logic [DUTY_W-1:0]        duty_now;
    logic                     dir_now;

    loop_report_t pending_reports[$];
    int           errors;

    function new();
      kp           = KP_RESET;
      ki           = '0;
      kd           = '0;
      alpha        = ALPHA_RESET;
      period       = PERIOD_RESET;
      limit        = LIMIT_RESET;
      filt_out_mem = '0;
      filt_in_mem  = '0;
      est_now      = '0;
      err_prev     = '0;
      err_prev2    = '0;
      ctrl_now     = '0;
      duty_now     = '0;
      dir_now      = 1'b0;
      errors       = 0;
    endfunction

    function logic signed [DATA_W-1:0] sat_word(longint x);
      longint hi, lo;
      hi = (longint'(1) <<< (DATA_W - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi[DATA_W-1:0];
      if (x < lo) return lo[DATA_W-1:0];
      return x[DATA_W-1:0];
    endfunction

    // gain * diff scaled down by 2^FRAC with floor, clamped to +/-2^61
    function longint scaled_term(longint gain, longint diff);
      logic signed [127:0] prod, cap;
      cap  = 128'sd1 <<< 61;
      prod = 128'(gain) * 128'(diff);
      prod = prod >>> FRAC_BITS_TB;
      if (prod > cap) prod = cap;
      if (prod < -cap) prod = -cap;
      return prod[63:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] wdata);
      case (idx)
        REG_KP:     kp     = wdata;
        REG_KI:     ki     = wdata;
        REG_KD:     kd     = wdata;
        REG_ALPHA:  alpha  = wdata[ALPHA_W-1:0];
        REG_PERIOD: period = wdata[DUTY_W-1:0];
        REG_LIMIT:  limit  = wdata[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
      longint       w_in, acc, e, e1, e2, u, mag, d;
      loop_report_t r;
      case (cmd)
        CMD_SAMPLE: begin
          // estimate lags by one sample: it blends the previous raw sample
          w_in = (longint'(1) <<< ALPHA_W) - longint'(alpha);
          acc  = w_in * longint'(filt_in_mem) + longint'(alpha) * longint'(filt_out_mem);
          est_now      = sat_word(acc >>> ALPHA_W);
          filt_out_mem = est_now;
          filt_in_mem  = val;
        end
        CMD_CONTROL: begin
          e  = sat_word(longint'(val) - longint'(est_now));
          e1 = err_prev;
          e2 = err_prev2;
          u  = longint'(ctrl_now) + scaled_term(kp, e - e1) + scaled_term(ki, e + e1)
             + scaled_term(kd, e - 2 * e1 + e2);
          ctrl_now  = sat_word(u);
          err_prev2 = err_prev;
          err_prev  = e[DATA_W-1:0];
          mag = (ctrl_now < 0) ? -longint'(ctrl_now) : longint'(ctrl_now);
          d   = ((mag * longint'(period)) >>> FRAC_BITS_TB) / 100;
          if (d > longint'(limit)) d = longint'(limit);
          duty_now = d[DUTY_W-1:0];
          dir_now  = (val < 0);
        end
        CMD_RESTART: begin
          err_prev  = '0;
          err_prev2 = '0;
          ctrl_now  = '0;
          est_now   = '0;
        end
        default: ;
      endcase
      r.est  = est_now;
      r.ctrl = ctrl_now;
      r.duty = duty_now;
      r.dir  = dir_now;
      pending_reports.push_back(r);
    endfunction

    function void flag(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_report(loop_report_t got);
      loop_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none actual %h",
                 $time, got);
        return;
      end
      want = pending_reports.pop_front();
      if (got.est !== want.est)   flag("speed_estimate", want.est, got.est);
      if (got.ctrl !== want.ctrl) flag("control_value", want.ctrl, got.ctrl);
      if (got.duty !== want.duty) flag("duty", want.duty, got.duty);
      if (got.dir !== want.dir)   flag("direction", want.dir, got.dir);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   quiet_cycles;

  pid_loop_scoreboard sb = new();

  fipid_in_if  in_if ();
  fipid_out_if out_if ();
  fipid_cfg_if cfg_if ();

  filtered_incremental_pid_speed_top #(
    .FRAC_BITS(FRAC_BITS_TB)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: stall at random, check each accepted beat
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_report(loop_report_t'{out_if.speed_estimate, out_if.control_value,
                                     out_if.duty, out_if.direction});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_command(cmd, val);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] wdata);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= wdata;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, wdata);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // drop valid, wait for every pending result, then let the datapath go quiet
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 8 << 16)) - (4 << 16);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_speed();
    case ($urandom_range(0, 15))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return MAX_WORD;
          1: return MIN_WORD;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 393216000)) - 196608000;  // +/-3000 rpm
    endcase
  endfunction

  // 16-bit register word with random upper bits, which the block must drop
  function automatic logic [DATA_W-1:0] short_word(logic [15:0] v);
    return {16'($urandom), v};
  endfunction

  task automatic configure_phase(int ph);
    case (ph)
      0: begin
        write_reg(REG_KP, 32'd65536);
        write_reg(REG_KI, 32'd3277);
        write_reg(REG_KD, 32'd655);
        write_reg(REG_ALPHA, 32'd24109);
        write_reg(REG_PERIOD, 32'd1000);
        write_reg(REG_LIMIT, 32'd90);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
      end
      1: begin
        write_reg(REG_KP, rand_gain());
        write_reg(REG_KI, rand_gain());
        write_reg(REG_KD, rand_gain());
        write_reg(REG_ALPHA, short_word(16'd0));
        write_reg(REG_PERIOD, short_word(16'hFFFF));
        write_reg(REG_LIMIT, short_word(16'hFFFF));
      end
      2: begin
        write_reg(REG_KP, MAX_WORD);
        write_reg(REG_KI, MIN_WORD);
        write_reg(REG_KD, MAX_WORD);
        write_reg(REG_ALPHA, 32'h0000_FFFF);
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_LIMIT, 32'h0000_FFFF);
      end
      3: begin
        write_reg(REG_KP, MIN_WORD);
        write_reg(REG_KI, MAX_WORD);
        write_reg(REG_KD, MIN_WORD);
        write_reg(REG_ALPHA, short_word(16'($urandom)));
        write_reg(REG_PERIOD, short_word(16'($urandom)));
        write_reg(REG_LIMIT, 32'd0);
      end
      default: begin
        write_reg(REG_KP, rand_gain());
        write_reg(REG_KI, rand_gain());
        write_reg(REG_KD, rand_gain());
        write_reg(REG_ALPHA, short_word(16'($urandom)));
        write_reg(REG_PERIOD, short_word(16'($urandom_range(0, 4000))));
        write_reg(REG_LIMIT, short_word($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom)));
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      end
    endcase
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    int               pick;

    rst_n          = 1'b0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    quiet_cycles   = 0;
    in_if.valid    = 1'b0;
    in_if.command  = CMD_SAMPLE;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_KP;
    cfg_if.data    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, each command and the unused code
    send_command(CMD_SAMPLE, MAX_WORD);
    send_command(CMD_SAMPLE, MAX_WORD);
    send_command(CMD_SAMPLE, MIN_WORD);
    send_command(CMD_SAMPLE, MIN_WORD);
    send_command(CMD_SAMPLE, '0);
    send_command(CMD_CONTROL, MAX_WORD);
    send_command(CMD_CONTROL, MIN_WORD);
    send_command(CMD_CONTROL, -1);
    send_command(CMD_CONTROL, '0);
    send_command(CMD_CONTROL, 32'sd100 <<< 16);
    send_command(CMD_UNUSED, $urandom);
    send_command(CMD_RESTART, $urandom);
    // restart keeps filter memory: the next sample blends the old raw value
    send_command(CMD_SAMPLE, 32'sd1000 <<< 16);
    send_command(CMD_SAMPLE, 32'sd1000 <<< 16);
    send_command(CMD_CONTROL, 32'sd1500 <<< 16);
    send_command(CMD_CONTROL, -(32'sd1500 <<< 16));
    send_command(CMD_SAMPLE, -5);
    send_command(CMD_CONTROL, MAX_WORD);
    send_command(CMD_CONTROL, MAX_WORD);
    send_command(CMD_RESTART, '0);
    send_command(CMD_UNUSED, MIN_WORD);
    send_command(CMD_CONTROL, MIN_WORD);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      configure_phase(ph);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 47; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 47; end
        default: begin src_idle_pct = 8; snk_idle_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      cmd = CMD_SAMPLE;
        else if (pick < 90) cmd = CMD_CONTROL;
        else if (pick < 95) cmd = CMD_RESTART;
        else                cmd = CMD_UNUSED;
        send_command(cmd, rand_speed());
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
